>>> design/mmde_pkg.sv
// Shared definitions for the matrix multiply dot engine.
// Opcodes, register indexes, field widths, controller/datapath structs, index helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmde_pkg;

  // defaults for the top-level parameters
  localparam int MAX_DIM_DEF = 16;
  localparam int LANES_DEF   = 4;

  // input field widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 4;
  localparam int VALUE_W = 16;
  localparam int IN_TDATA_W = 24;   // row, col, value

  // result field widths
  localparam int ACC_W       = 36;  // Q20.16 product field and lane sums
  localparam int PROD_W      = 32;  // one Q8.8 x Q8.8 term
  localparam int OUT_TDATA_W = 40;  // product padded to whole bytes

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int DIM_REG_W  = 5;
  localparam int KG_REG_W   = 3;
  localparam int GROUP_LOG2 = 2;    // inner length = k_groups * 4

  localparam logic [CFG_IDX_W-1:0] CFG_M_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_N_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_K_GROUPS = 2'd2;

  localparam logic [DIM_REG_W-1:0] M_ROWS_RST   = 5'd16;
  localparam logic [DIM_REG_W-1:0] N_COLS_RST   = 5'd16;
  localparam logic [KG_REG_W-1:0]  K_GROUPS_RST = 3'd4;

  // operations
  localparam logic [OP_W-1:0] OP_WR_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_B = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  typedef struct packed {
    logic wr_en;      // write request accepted
    logic rd_start;   // read request accepted: latch indices, clear lanes
    logic rd_issue;   // issue one step of lane reads
    logic reduce;     // one level of the lane adder tree
    logic load_out;   // load the result register
  } mmde_cmd_t;

  typedef struct packed {
    logic op_write;
    logic op_read;
    logic in_oor;     // read index outside the active matrix
    logic in_empty;   // inner length is zero
    logic last_step;
    logic pipe_busy;
    logic red_done;
  } mmde_stat_t;

  // k / lanes as a compare table, k is at most 15
  function automatic logic [IDX_W-1:0] word_of(input logic [IDX_W-1:0] k, input int lanes);
    logic [IDX_W-1:0] w;
    w = '0;
    for (int i = 0; i < (1 << IDX_W); i++) begin
      if (int'(k) >= i * lanes && int'(k) < (i + 1) * lanes) w = IDX_W'(i);
    end
    return w;
  endfunction

  // k mod lanes
  function automatic logic [IDX_W-1:0] bank_of(input logic [IDX_W-1:0] k, input int lanes);
    return k - IDX_W'(int'(word_of(k, lanes)) * lanes);
  endfunction

endpackage

`default_nettype wire

>>> design/mmde_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mmde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/mmde_ctrl.sv
// Controller for the dot engine: request handshake, read sequencing, result register valid.
// Depends on mmde_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module mmde_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  input  wire mmde_pkg::mmde_stat_t stat,
  output mmde_pkg::mmde_cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RUN    = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_REDUCE = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state, state_next;
  logic       accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.wr_en    = accept && stat.op_write;
    cmd.rd_start = accept && stat.op_read;
    case (state)
      ST_IDLE: begin
        if (accept && stat.op_read) begin
          state_next = (stat.in_oor || stat.in_empty) ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.rd_issue = 1'b1;
        if (stat.last_step) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (stat.red_done) state_next = ST_FINISH;
        else cmd.reduce = 1'b1;
      end
      ST_FINISH: begin
        // result register free or emptied this cycle
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> design/mmde_dp.sv
// Datapath for the dot engine: config registers, banked A / B^T stores,
// lane multipliers and accumulators, adder tree, result register.
// Depends on mmde_pkg and mmde_ram.
`timescale 1ns / 1ps
`default_nettype none

module mmde_dp #(
  parameter int MAX_DIM = mmde_pkg::MAX_DIM_DEF,
  parameter int LANES   = mmde_pkg::LANES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [mmde_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mmde_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [mmde_pkg::OP_W-1:0]           in_op,
  input  wire logic [mmde_pkg::IN_TDATA_W-1:0]     in_data,
  input  wire mmde_pkg::mmde_cmd_t                 cmd,
  output mmde_pkg::mmde_stat_t                     stat,
  output logic      [mmde_pkg::ACC_W-1:0]          product,
  output logic                                     status
);

  localparam int IDX_W  = mmde_pkg::IDX_W;
  localparam int ACC_W  = mmde_pkg::ACC_W;
  localparam int KW     = (MAX_DIM + LANES - 1) / LANES;     // words per row in a bank
  localparam int DEPTH  = MAX_DIM * KW;
  localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int SW     = KW > 1 ? $clog2(KW) : 1;
  localparam int CW     = $clog2(MAX_DIM + 1) > 5 ? $clog2(MAX_DIM + 1) : 5;
  localparam int LP     = 1 << $clog2(LANES);                 // lanes rounded up for the tree
  localparam int RED_STEPS = $clog2(LP);
  localparam int RW     = RED_STEPS > 0 ? $clog2(RED_STEPS + 1) : 1;

  // ---------------- configuration ----------------
  logic [mmde_pkg::DIM_REG_W-1:0] m_rows, n_cols;
  logic [mmde_pkg::KG_REG_W-1:0]  k_groups;
  logic [CW-1:0] m_ext, n_ext, kk_ext, m_sat, n_sat, kk;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_rows   <= mmde_pkg::M_ROWS_RST;
      n_cols   <= mmde_pkg::N_COLS_RST;
      k_groups <= mmde_pkg::K_GROUPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mmde_pkg::CFG_M_ROWS:   m_rows   <= cfg_data[mmde_pkg::DIM_REG_W-1:0];
        mmde_pkg::CFG_N_COLS:   n_cols   <= cfg_data[mmde_pkg::DIM_REG_W-1:0];
        mmde_pkg::CFG_K_GROUPS: k_groups <= cfg_data[mmde_pkg::KG_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign m_ext  = CW'(m_rows);
  assign n_ext  = CW'(n_cols);
  assign kk_ext = CW'(k_groups) << mmde_pkg::GROUP_LOG2;
  assign m_sat  = (m_ext  > CW'(MAX_DIM)) ? CW'(MAX_DIM) : m_ext;
  assign n_sat  = (n_ext  > CW'(MAX_DIM)) ? CW'(MAX_DIM) : n_ext;
  assign kk     = (kk_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : kk_ext;

  // ---------------- request decode ----------------
  logic [IDX_W-1:0]              in_row, in_col;
  logic [mmde_pkg::VALUE_W-1:0]  in_value;

  assign in_row   = in_data[IDX_W-1:0];
  assign in_col   = in_data[2*IDX_W-1:IDX_W];
  assign in_value = in_data[2*IDX_W+mmde_pkg::VALUE_W-1:2*IDX_W];

  assign stat.op_write = (in_op == mmde_pkg::OP_WR_A) || (in_op == mmde_pkg::OP_WR_B);
  assign stat.op_read  = (in_op == mmde_pkg::OP_READ);
  assign stat.in_oor   = (CW'(in_row) >= m_sat) || (CW'(in_col) >= n_sat);
  assign stat.in_empty = (kk == '0);

  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] base, input int word);
    return AW'(int'(base) * KW + word);
  endfunction

  // A(r,k) lives in bank k%LANES at r*KW + k/LANES; B^T(c,k) likewise with base c
  logic             wr_a_en, wr_b_en;
  logic [IDX_W-1:0] wr_k, wr_base, wr_bank;
  logic [AW-1:0]    wr_addr;

  assign wr_a_en = cmd.wr_en && (in_op == mmde_pkg::OP_WR_A) &&
                   (CW'(in_row) < m_sat) && (CW'(in_col) < kk);
  assign wr_b_en = cmd.wr_en && (in_op == mmde_pkg::OP_WR_B) &&
                   (CW'(in_row) < kk) && (CW'(in_col) < n_sat);
  assign wr_k    = (in_op == mmde_pkg::OP_WR_A) ? in_col : in_row;
  assign wr_base = (in_op == mmde_pkg::OP_WR_A) ? in_row : in_col;
  assign wr_bank = mmde_pkg::bank_of(wr_k, LANES);
  assign wr_addr = addr_of(wr_base, int'(mmde_pkg::word_of(wr_k, LANES)));

  // ---------------- read sequencing ----------------
  logic [IDX_W-1:0] row_q, col_q;
  logic             oor_q;
  logic [SW-1:0]    step;
  logic [AW-1:0]    rd_a_addr, rd_b_addr;
  logic [LANES-1:0] mask0, mask1, mask2;
  logic             v1, v2;
  logic [RW-1:0]    red_cnt;

  assign rd_a_addr = addr_of(row_q, int'(step));
  assign rd_b_addr = addr_of(col_q, int'(step));

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mask0[l] = (int'(step) * LANES + l) < int'(kk);
    end
  end

  assign stat.last_step = ((int'(step) + 1) * LANES) >= int'(kk);
  assign stat.pipe_busy = v1 || v2;
  assign stat.red_done  = (red_cnt == RW'(RED_STEPS));

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= '0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      red_cnt <= '0;
    end else begin
      v1 <= cmd.rd_issue;
      v2 <= v1;
      if (cmd.rd_start) begin
        step    <= '0;
        red_cnt <= '0;
      end else begin
        if (cmd.rd_issue) step <= step + SW'(1);
        if (cmd.reduce) red_cnt <= red_cnt + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      row_q <= in_row;
      col_q <= in_col;
      oor_q <= stat.in_oor;
    end
    mask1 <= mask0;
    mask2 <= mask1;
  end

  // ---------------- lanes ----------------
  logic        [mmde_pkg::VALUE_W-1:0] a_rd [LANES];
  logic        [mmde_pkg::VALUE_W-1:0] b_rd [LANES];
  logic signed [mmde_pkg::PROD_W-1:0]  prod [LANES];
  logic signed [ACC_W-1:0]             lane [LP];

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mmde_ram #(.WIDTH(mmde_pkg::VALUE_W), .DEPTH(DEPTH)) u_a_ram (
      .clk   (clk),
      .we    (wr_a_en && (wr_bank == IDX_W'(g))),
      .waddr (wr_addr),
      .wdata (in_value),
      .raddr (rd_a_addr),
      .rdata (a_rd[g])
    );
    mmde_ram #(.WIDTH(mmde_pkg::VALUE_W), .DEPTH(DEPTH)) u_b_ram (
      .clk   (clk),
      .we    (wr_b_en && (wr_bank == IDX_W'(g))),
      .waddr (wr_addr),
      .wdata (in_value),
      .raddr (rd_b_addr),
      .rdata (b_rd[g])
    );

    always_ff @(posedge clk) begin
      prod[g] <= $signed(a_rd[g]) * $signed(b_rd[g]);
    end
  end

  // lanes at or above LANES only ever hold zero; the tree folds pairs each cycle
  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      for (int i = 0; i < LP; i++) lane[i] <= '0;
    end else if (cmd.reduce) begin
      for (int i = 0; i < LP / 2; i++) lane[i] <= lane[2*i] + lane[2*i+1];
      for (int i = LP / 2; i < LP; i++) lane[i] <= '0;
    end else if (v2) begin
      for (int l = 0; l < LANES; l++) begin
        if (mask2[l]) lane[l] <= lane[l] + ACC_W'(prod[l]);
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      product <= oor_q ? '0 : lane[0];
      status  <= oor_q;
    end
  end

endmodule

`default_nettype wire

>>> design/matrix_multiply_dot_engine_core.sv
// Top level of the matrix multiply dot engine (C = A * B element reads).
// Depends on mmde_pkg, mmde_ctrl, mmde_dp (and mmde_ram through the datapath).
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  s_*      | s_tvalid / s_tready  | tuser: operation; tdata: row, col, value
//  m_*      | m_tvalid / m_tready  | tdata: product (36b, zero pad); tuser: status
//  cfg_*    | cfg_valid/cfg_ready  | cfg_index: register, cfg_data: value
//
// Writes finish when accepted. Out-of-range reads and reads with a zero inner length go
// from the request straight to the result load.
// A read in range issues its lane reads step by step over the inner length kk, drains
// the two-stage read/multiply pipe, runs the lane adder tree, then loads the result.
// Reset is synchronous; the element stores are not cleared and hold garbage until written.
// The result sits in an output register; a new request is taken while it waits,
// and a stalled m_ tready holds the engine only once its next result is ready.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_dot_engine_core #(
  parameter int MAX_DIM = mmde_pkg::MAX_DIM_DEF,
  parameter int LANES   = mmde_pkg::LANES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // request stream
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [mmde_pkg::IN_TDATA_W-1:0]      s_tdata,   // [3:0] row, [7:4] col, [23:8] value
  input  wire logic [mmde_pkg::OP_W-1:0]            s_tuser,   // [1:0] operation
  // result stream
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic      [mmde_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [35:0] product, [39:36] zero
  output logic      [0:0]                           m_tuser,   // [0] status
  // configuration writes
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [mmde_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mmde_pkg::CFG_DATA_W-1:0]      cfg_data
);

  mmde_pkg::mmde_cmd_t  cmd;
  mmde_pkg::mmde_stat_t stat;
  logic [mmde_pkg::ACC_W-1:0] product;
  logic                       status;

  assign cfg_ready = 1'b1;

  mmde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mmde_dp #(.MAX_DIM(MAX_DIM), .LANES(LANES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_op     (s_tuser),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .product   (product),
    .status    (status)
  );

  assign m_tdata    = mmde_pkg::OUT_TDATA_W'(product);
  assign m_tuser[0] = status;

endmodule

`default_nettype wire

>>> design/mmde_chk.sv
// Port-level checker for matrix_multiply_dot_engine_core, attached by bind.
// Depends on mmde_pkg for opcodes and widths.
`timescale 1ns / 1ps
`default_nettype none

module mmde_chk (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 s_tvalid,
  input wire logic                                 s_tready,
  input wire logic [mmde_pkg::OP_W-1:0]            s_tuser,
  input wire logic                                 m_tvalid,
  input wire logic                                 m_tready,
  input wire logic [mmde_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input wire logic [0:0]                           m_tuser
);

  // no result appears straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an out-of-range read reports a zero product
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("nonzero product with error status");

  // a read request closes the request side while it is worked on
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == mmde_pkg::OP_READ) |=> !s_tready)
    else $error("request taken during a read");

endmodule

bind matrix_multiply_dot_engine_core mmde_chk u_mmde_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

>>> dv/matrix_multiply_dot_engine_core_tb.sv
// Testbench for matrix_multiply_dot_engine_core: element writes of A and B, C element reads.
// Results are checked in order against a behavioral predictor kept in this file.
// Depends on mmde_pkg and the RTL of the dot engine.
`timescale 1ns / 1ps

module matrix_multiply_dot_engine_core_tb;
  import mmde_pkg::*;

  localparam int DIM           = MAX_DIM_DEF;
  localparam int LANE_CNT      = LANES_DEF;
  localparam int SETTLE_CYCLES = 16;    // extra idle wait in settle() once every result is back
  localparam int QUIET_LIMIT   = 2000;
  localparam int REPORT_MAX    = 10;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;   // unused opcode, dropped by the block

  typedef struct packed {
    logic [ACC_W-1:0] product;
    logic             status;
  } c_elem_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [OP_W-1:0]        s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0]             m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // predictor state
  logic signed [VALUE_W-1:0] a_mem  [DIM*DIM];
  logic signed [VALUE_W-1:0] bt_mem [DIM*DIM];
  logic [DIM_REG_W-1:0]      m_reg  = M_ROWS_RST;
  logic [DIM_REG_W-1:0]      n_reg  = N_COLS_RST;
  logic [KG_REG_W-1:0]       kg_reg = K_GROUPS_RST;
  c_elem_t                   c_expected_q [$];
  c_elem_t                   c_head;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int err_count   = 0;
  int quiet_cycles = 0;

  matrix_multiply_dot_engine_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int clip_dim(input int v);
    return (v > DIM) ? DIM : v;
  endfunction

  // apply one accepted request to the predictor, queue the C element for reads
  function automatic void model_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                                        input logic [IDX_W-1:0] col,
                                        input logic signed [VALUE_W-1:0] value);
    int                        m;
    int                        n;
    int                        kk;
    c_elem_t                   res;
    logic signed [ACC_W-1:0]   lane_sum [LANE_CNT];
    logic signed [ACC_W-1:0]   total;
    logic signed [PROD_W-1:0]  term;
    m  = clip_dim(int'(m_reg));
    n  = clip_dim(int'(n_reg));
    kk = clip_dim(int'(kg_reg) * 4);
    case (op)
      OP_WR_A: begin
        if (row < m && col < kk) a_mem[int'(row) * DIM + int'(col)] = value;
      end
      OP_WR_B: begin
        if (row < kk && col < n) bt_mem[int'(col) * DIM + int'(row)] = value;
      end
      OP_READ: begin
        if (row >= m || col >= n) begin
          res.product = '0;
          res.status  = 1'b1;
        end else begin
          for (int l = 0; l < LANE_CNT; l++) lane_sum[l] = '0;
          for (int k = 0; k < kk; k++) begin
            term = a_mem[int'(row) * DIM + k] * bt_mem[int'(col) * DIM + k];
            lane_sum[k % LANE_CNT] += term;
          end
          total = '0;
          for (int l = 0; l < LANE_CNT; l++) total += lane_sum[l];
          res.product = total;
          res.status  = 1'b0;
        end
        c_expected_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // one request on the s_ stream; called right after a rising edge
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col, input logic [VALUE_W-1:0] value);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {value, col, row};
    do @(posedge clk); while (!s_tready);
    model_request(op, row, col, value);
  endtask

  // hold the sender until every C element is back and the pipe has drained
  task automatic settle();
    s_tvalid <= 1'b0;
    while (c_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all three registers, only while the engine is idle
  task automatic program_dims(input logic [DIM_REG_W-1:0] m, input logic [DIM_REG_W-1:0] n,
                              input logic [KG_REG_W-1:0] kg);
    logic [CFG_IDX_W-1:0]  idx  [3];
    logic [CFG_DATA_W-1:0] data [3];
    idx[0]  = CFG_M_ROWS;
    idx[1]  = CFG_N_COLS;
    idx[2]  = CFG_K_GROUPS;
    data[0] = m;
    data[1] = n;
    data[2] = {2'($urandom_range(0, 3)), kg};   // upper bits are don't-care for k_groups
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= data[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_M_ROWS:   m_reg  = data[i];
        CFG_N_COLS:   n_reg  = data[i];
        CFG_K_GROUPS: kg_reg = data[i][KG_REG_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int sender, input int receiver);
    idle_pct  = sender;
    stall_pct = receiver;
  endtask

  // result side: receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (c_expected_q.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_MAX)
          $display("unexpected C element: product %h status %b", m_tdata[ACC_W-1:0], m_tuser[0]);
      end else begin
        c_head = c_expected_q.pop_front();
        if (m_tdata[ACC_W-1:0] !== c_head.product || m_tuser[0] !== c_head.status) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display("C mismatch: expected product %h status %b, got product %h status %b",
                     c_head.product, c_head.status, m_tdata[ACC_W-1:0], m_tuser[0]);
        end
      end
    end
  end

  // watchdog on cycles with no request moving on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // every element of A and B gets written at the reset sizes, so no read touches garbage
  task automatic test_preload();
    set_idling(0, 0);
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        send_request(OP_WR_A, IDX_W'(r), IDX_W'(c), 16'($urandom));
        send_request(OP_WR_B, IDX_W'(r), IDX_W'(c), 16'($urandom));
      end
    end
    settle();
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    program_dims(5'd16, 5'd16, 3'd1);
    // most negative times most negative in every term
    for (int k = 0; k < 4; k++) begin
      send_request(OP_WR_A, 4'd0, IDX_W'(k), 16'h8000);
      send_request(OP_WR_B, IDX_W'(k), 4'd15, 16'h8000);
    end
    send_request(OP_READ, 4'd0, 4'd15, '0);
    for (int k = 0; k < 4; k++) send_request(OP_WR_A, 4'd15, IDX_W'(k), 16'h7fff);
    send_request(OP_READ, 4'd15, 4'd15, '0);
    // unused opcode and a write past the inner length must change nothing
    send_request(OP_NONE, 4'd0, 4'd0, 16'h7fff);
    send_request(OP_WR_A, 4'd0, 4'd4, 16'h7fff);
    send_request(OP_READ, 4'd0, 4'd15, '0);
    settle();
    // empty inner length, and reads past rows / columns
    program_dims(5'd3, 5'd2, 3'd0);
    send_request(OP_READ, 4'd0, 4'd0, '0);
    send_request(OP_READ, 4'd3, 4'd0, '0);
    send_request(OP_READ, 4'd0, 4'd2, '0);
    settle();
    // registers past MAX_DIM saturate
    program_dims(5'd31, 5'd31, 3'd7);
    send_request(OP_READ, 4'd15, 4'd15, '0);
    send_request(OP_READ, 4'd0, 4'd15, '0);
    settle();
    // zero rows: every read is out of range, every A write dropped
    program_dims(5'd0, 5'd0, 3'd4);
    send_request(OP_WR_A, 4'd0, 4'd0, 16'h1234);
    send_request(OP_READ, 4'd0, 4'd0, '0);
    settle();
  endtask

  task automatic test_random();
    int                   sel;
    int                   seg;
    logic [OP_W-1:0]      op;
    logic [VALUE_W-1:0]   value;
    logic [DIM_REG_W-1:0] m;
    logic [DIM_REG_W-1:0] n;
    logic [KG_REG_W-1:0]  kg;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(71, 0);
        2: set_idling(0, 71);
        default: set_idling(18, 18);
      endcase
      for (int s = 0; s < 2; s++) begin
        seg = ph * 2 + s;
        case (seg)
          0: begin m = 5'd1;  n = 5'd1;  kg = 3'd1; end
          1: begin m = 5'd16; n = 5'd16; kg = 3'd4; end
          2: begin m = 5'd31; n = 5'd31; kg = 3'd7; end
          3: begin m = 5'd16; n = 5'd16; kg = 3'd5; end
          default: begin
            m  = 5'($urandom_range(1, 16));
            n  = 5'($urandom_range(1, 16));
            kg = 3'($urandom_range(1, 4));
          end
        endcase
        program_dims(m, n, kg);
        for (int i = 0; i < 150; i++) begin
          sel = $urandom_range(0, 99);
          if (sel < 35)      op = OP_READ;
          else if (sel < 65) op = OP_WR_A;
          else if (sel < 95) op = OP_WR_B;
          else               op = OP_NONE;
          sel = $urandom_range(0, 9);
          if (sel == 0)      value = 16'h8000;
          else if (sel == 1) value = 16'h7fff;
          else               value = 16'($urandom);
          send_request(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), value);
          if (i == 75) settle();   // sender holds off until all results are back
        end
        settle();
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_preload();
    test_directed();
    test_random();
    settle();
    if (c_expected_q.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mmde_pkg.sv
design/mmde_ram.sv
design/mmde_ctrl.sv
design/mmde_dp.sv
design/matrix_multiply_dot_engine_core.sv
design/mmde_chk.sv
dv/matrix_multiply_dot_engine_core_tb.sv
